>>> hw/rtl/dobq_pkg.sv
// Package for the drop-oldest burst queue: sizes, codes, command and result types.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none
package dobq_pkg;

	// Storage depth of the descriptor queue.
	localparam int DEPTH    = 16;
	localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	// Fixed field widths.
	localparam int MODE_W   = 2;
	localparam int HANDLE_W = 32;
	localparam int MASK_W   = 64;
	localparam int PCNT_W   = 7;
	localparam int OCC_W    = 5;
	localparam int PRESS_W  = 8;
	localparam int LIMIT_W  = 5;

	// Width for comparing the entry count against the limit.
	localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	// Pressure divider: dividend below limit*256, one quotient bit per step.
	localparam int DIV_W    = LIMIT_W + PRESS_W;
	localparam int STEP_W   = $clog2(PRESS_W);
	// Mask bits counted per divider step, so popcount finishes with the divide.
	localparam int CHUNK    = MASK_W / PRESS_W;

	localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = LIMIT_W'(10);
	localparam logic [PRESS_W-1:0] PRESS_MAX     = PRESS_W'(255);

	// Command queue between front and back.
	localparam int FIFO_DEPTH = 2;
	localparam int FPTR_W     = 1;
	localparam int FCNT_W     = 2;

	// Configuration port.
	localparam int APB_DW    = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_DEPTH = REG_IDX_W'(0);

	// Mode codes on the input channel.
	localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_CLEAR,
		OP_QUERY
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [HANDLE_W-1:0]  handle;
		logic [MASK_W-1:0]    mask;
		logic [LIMIT_W-1:0]   limit;
	} cmd_t;

	typedef struct packed {
		logic                 pop_valid;
		logic [HANDLE_W-1:0]  pop_handle;
		logic [MASK_W-1:0]    pop_mask;
		logic [PCNT_W-1:0]    packet_count;
		logic                 drop_valid;
		logic [HANDLE_W-1:0]  drop_handle;
		logic [MASK_W-1:0]    drop_mask;
		logic [OCC_W-1:0]     occupancy;
		logic [PRESS_W-1:0]   pressure;
	} result_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CALC,
		B_LOAD
	} back_state_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dobq_in_if.sv
// Input channel of the drop-oldest burst queue: valid/ready plus one descriptor command.
// Depends on dobq_pkg for field widths.
`default_nettype none
interface dobq_in_if;
	logic                           valid;
	logic                           ready;
	logic [dobq_pkg::MODE_W-1:0]    mode;
	logic [dobq_pkg::HANDLE_W-1:0]  burst_handle;
	logic [dobq_pkg::MASK_W-1:0]    burst_mask;

	modport source (output valid, mode, burst_handle, burst_mask, input ready);
	modport sink   (input valid, mode, burst_handle, burst_mask, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dobq_out_if.sv
// Result channel of the drop-oldest burst queue: valid/ready plus one result item.
// Depends on dobq_pkg for field widths.
`default_nettype none
interface dobq_out_if;
	logic                           valid;
	logic                           ready;
	logic                           pop_valid;
	logic [dobq_pkg::HANDLE_W-1:0]  pop_handle;
	logic [dobq_pkg::MASK_W-1:0]    pop_mask;
	logic [dobq_pkg::PCNT_W-1:0]    packet_count;
	logic                           drop_valid;
	logic [dobq_pkg::HANDLE_W-1:0]  drop_handle;
	logic [dobq_pkg::MASK_W-1:0]    drop_mask;
	logic [dobq_pkg::OCC_W-1:0]     occupancy;
	logic [dobq_pkg::PRESS_W-1:0]   pressure;

	modport source (output valid, pop_valid, pop_handle, pop_mask, packet_count,
		drop_valid, drop_handle, drop_mask, occupancy, pressure, input ready);
	modport sink   (input valid, pop_valid, pop_handle, pop_mask, packet_count,
		drop_valid, drop_handle, drop_mask, occupancy, pressure, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dobq_front.sv
// Front end: accepts input transfers, decodes the mode and resolves the effective limit.
// Depends on dobq_pkg and dobq_in_if; feeds dobq_cmd_fifo.
`default_nettype none
module dobq_front (
	dobq_in_if.sink                        items,
	input  logic [dobq_pkg::LIMIT_W-1:0]   max_depth,
	input  logic                           fifo_full,
	output logic                           push,
	output dobq_pkg::cmd_t                 cmd
);

	logic [dobq_pkg::LIMIT_W-1:0] lim_raw;

	assign items.ready = !fifo_full;
	assign push        = items.valid && !fifo_full;

	always_comb begin
		lim_raw = (max_depth == '0) ? dobq_pkg::DEFAULT_LIMIT : max_depth;
		cmd.handle = items.burst_handle;
		cmd.mask   = items.burst_mask;
		// saturate the limit to the storage depth
		if (dobq_pkg::CMP_W'(lim_raw) > dobq_pkg::CMP_W'(dobq_pkg::DEPTH)) begin
			cmd.limit = dobq_pkg::LIMIT_W'(dobq_pkg::DEPTH);
		end else begin
			cmd.limit = lim_raw;
		end
		unique case (items.mode)
			dobq_pkg::MODE_PUSH:  cmd.op = dobq_pkg::OP_PUSH;
			dobq_pkg::MODE_POP:   cmd.op = dobq_pkg::OP_POP;
			dobq_pkg::MODE_CLEAR: cmd.op = dobq_pkg::OP_CLEAR;
			dobq_pkg::MODE_QUERY: cmd.op = dobq_pkg::OP_QUERY;
			default:              cmd.op = dobq_pkg::OP_QUERY;
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/dobq_cmd_fifo.sv
// Two-entry command queue that decouples the front end from the back end.
// Depends on dobq_pkg for the command type and depth.
`default_nettype none
module dobq_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dobq_pkg::cmd_t  push_cmd,
	input  logic            pop,
	output dobq_pkg::cmd_t  head_cmd,
	output logic            full,
	output logic            empty
);

	dobq_pkg::cmd_t                 slot_q [dobq_pkg::FIFO_DEPTH];
	logic [dobq_pkg::FPTR_W-1:0]    wr_q;
	logic [dobq_pkg::FPTR_W-1:0]    rd_q;
	logic [dobq_pkg::FCNT_W-1:0]    cnt_q;

	assign full     = (cnt_q == dobq_pkg::FCNT_W'(dobq_pkg::FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_cmd = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + dobq_pkg::FCNT_W'(push) - dobq_pkg::FCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/dobq_back.sv
// Back end: descriptor storage, queue pointers, pressure divider, popcount, result register.
// Depends on dobq_pkg and dobq_out_if; drains dobq_cmd_fifo.
`default_nettype none
module dobq_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fifo_empty,
	input  dobq_pkg::cmd_t  head_cmd,
	output logic            take,
	dobq_out_if.source      results
);

	dobq_pkg::back_state_t           state_q, state_d;
	logic                            load_out;

	logic [dobq_pkg::HANDLE_W-1:0]   handles_q [dobq_pkg::DEPTH];
	logic [dobq_pkg::MASK_W-1:0]     masks_q   [dobq_pkg::DEPTH];
	logic [dobq_pkg::PTR_W-1:0]      rp_q, wp_q;
	logic [dobq_pkg::CNT_W-1:0]      count_q;

	logic [dobq_pkg::STEP_W-1:0]     step_q;
	logic [dobq_pkg::DIV_W-1:0]      rem_q, dsr_q;
	logic [dobq_pkg::PRESS_W-1:0]    quo_q;
	logic                            sat_q;
	logic [dobq_pkg::MASK_W-1:0]     pmask_q;
	logic [dobq_pkg::PCNT_W-1:0]     pcnt_q;
	dobq_pkg::result_t               acc_q;
	dobq_pkg::result_t               rsp_q;
	logic                            out_valid_q;

	// execute-cycle signals
	logic [dobq_pkg::HANDLE_W-1:0]   rd_h;
	logic [dobq_pkg::MASK_W-1:0]     rd_m;
	logic                            dropping, popping, writing, clearing;
	logic [dobq_pkg::CNT_W-1:0]      cnt_mid, cnt_n;
	logic                            sat_n;
	logic [dobq_pkg::DIV_W-1:0]      dividend;
	logic                            ge;
	logic [dobq_pkg::PCNT_W-1:0]     chunk_ones;
	logic                            last_step;
	dobq_pkg::result_t               rsp_d;

	assign rd_h      = handles_q[rp_q];
	assign rd_m      = masks_q[rp_q];
	assign last_step = (step_q == dobq_pkg::STEP_W'(dobq_pkg::PRESS_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dobq_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		take     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			dobq_pkg::B_IDLE: begin
				if (!fifo_empty) begin
					take    = 1'b1;
					state_d = dobq_pkg::B_CALC;
				end
			end
			dobq_pkg::B_CALC: begin
				if (last_step) begin
					state_d = dobq_pkg::B_LOAD;
				end
			end
			dobq_pkg::B_LOAD: begin
				if (!out_valid_q || results.ready) begin
					load_out = 1'b1;
					state_d  = dobq_pkg::B_IDLE;
				end
			end
			default: state_d = dobq_pkg::B_IDLE;
		endcase
	end

	// queue update for the command at the head
	always_comb begin
		dropping = (head_cmd.op == dobq_pkg::OP_PUSH) && (count_q != '0) &&
			(dobq_pkg::CMP_W'(count_q) >= dobq_pkg::CMP_W'(head_cmd.limit));
		popping  = (head_cmd.op == dobq_pkg::OP_POP) && (count_q != '0);
		clearing = (head_cmd.op == dobq_pkg::OP_CLEAR);
		cnt_mid  = count_q - dobq_pkg::CNT_W'(dropping || popping);
		writing  = (head_cmd.op == dobq_pkg::OP_PUSH) &&
			(cnt_mid < dobq_pkg::CNT_W'(dobq_pkg::DEPTH));
		cnt_n    = clearing ? '0 : cnt_mid + dobq_pkg::CNT_W'(writing);
		sat_n    = (dobq_pkg::CMP_W'(cnt_n) >= dobq_pkg::CMP_W'(head_cmd.limit));
		// occupancy*255 as (occ << 8) - occ; only used below the limit
		if (sat_n || cnt_n == '0) begin
			dividend = '0;
		end else begin
			dividend = (dobq_pkg::DIV_W'(cnt_n) << dobq_pkg::PRESS_W) -
				dobq_pkg::DIV_W'(cnt_n);
		end
	end

	always_comb begin
		ge         = (rem_q >= dsr_q);
		chunk_ones = '0;
		for (int i = 0; i < dobq_pkg::CHUNK; i++) begin
			chunk_ones = chunk_ones + dobq_pkg::PCNT_W'(pmask_q[i]);
		end
	end

	// assemble the finished result
	always_comb begin
		rsp_d              = acc_q;
		rsp_d.packet_count = pcnt_q;
		rsp_d.pressure     = sat_q ? dobq_pkg::PRESS_MAX : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q        <= '0;
			wp_q        <= '0;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q <= cnt_n;
				step_q  <= '0;
				if (clearing) begin
					rp_q <= '0;
					wp_q <= '0;
				end else begin
					if (dropping || popping) begin
						rp_q <= dobq_pkg::next_ptr(rp_q);
					end
					if (writing) begin
						wp_q <= dobq_pkg::next_ptr(wp_q);
					end
				end
			end else if (state_q == dobq_pkg::B_CALC) begin
				step_q <= step_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && writing) begin
			handles_q[wp_q] <= head_cmd.handle;
			masks_q[wp_q]   <= head_cmd.mask;
		end
		if (take) begin
			acc_q.pop_valid    <= popping;
			acc_q.pop_handle   <= popping ? rd_h : '0;
			acc_q.pop_mask     <= popping ? rd_m : '0;
			acc_q.packet_count <= '0;
			acc_q.drop_valid   <= dropping;
			acc_q.drop_handle  <= dropping ? rd_h : '0;
			acc_q.drop_mask    <= dropping ? rd_m : '0;
			acc_q.occupancy    <= dobq_pkg::OCC_W'(cnt_n);
			acc_q.pressure     <= '0;
			pmask_q <= popping ? rd_m : '0;
			pcnt_q  <= '0;
			sat_q   <= sat_n;
			rem_q   <= dividend;
			dsr_q   <= dobq_pkg::DIV_W'(head_cmd.limit) << (dobq_pkg::PRESS_W - 1);
			quo_q   <= '0;
		end else if (state_q == dobq_pkg::B_CALC) begin
			// restoring divide, one quotient bit; count one chunk of the mask
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			dsr_q   <= dsr_q >> 1;
			quo_q   <= {quo_q[dobq_pkg::PRESS_W-2:0], ge};
			pmask_q <= pmask_q >> dobq_pkg::CHUNK;
			pcnt_q  <= pcnt_q + chunk_ones;
		end
		if (load_out) begin
			rsp_q <= rsp_d;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.pop_valid    = rsp_q.pop_valid;
	assign results.pop_handle   = rsp_q.pop_handle;
	assign results.pop_mask     = rsp_q.pop_mask;
	assign results.packet_count = rsp_q.packet_count;
	assign results.drop_valid   = rsp_q.drop_valid;
	assign results.drop_handle  = rsp_q.drop_handle;
	assign results.drop_mask    = rsp_q.drop_mask;
	assign results.occupancy    = rsp_q.occupancy;
	assign results.pressure     = rsp_q.pressure;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dobq_pkg::CNT_W'(dobq_pkg::DEPTH))
		else $error("entry count above depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == dobq_pkg::CNT_W'(dobq_pkg::DEPTH)) |-> (rp_q == wp_q))
		else $error("pointers disagree with empty or full count");

	a_calc_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dobq_pkg::B_CALC && last_step) |=> (state_q == dobq_pkg::B_LOAD))
		else $error("divider did not finish after its last step");

	a_pop_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(rsp_q.pop_valid && rsp_q.drop_valid))
		else $error("result reports both pop and drop");

	a_count_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp_q.pop_valid) |-> (rsp_q.packet_count == '0))
		else $error("packet count without a popped entry");

endmodule
`default_nettype wire

>>> hw/rtl/drop_oldest_burst_queue.sv
// Top level of the drop-oldest burst queue: configuration register and block wiring.
// Depends on dobq_pkg, dobq_in_if, dobq_out_if, dobq_front, dobq_cmd_fifo, dobq_back.
`default_nettype none
// A bounded FIFO of burst descriptors (32-bit handle, 64-bit packet mask) that
// returns exactly one result transfer for every input transfer. Modes: push,
// pop, clear all, status query. A push at or above the limit (max_depth, zero
// meaning ten, capped at the 16-entry storage) first drops the oldest entry and
// reports it so its packets can be freed. Every result carries the occupancy
// after the operation and the pressure occupancy*255/limit, saturated at 255.
// In the back end each item passes an execute state, eight steps of the
// shared bit-serial pressure divider (which also counts eight mask bits per
// step for packet_count) and a load of the output register once it is free. A two-entry
// command queue lets the front end keep taking transfers while the back end
// works, and the output register holds a result while the next item executes.
// The configuration register sits at byte address 0 of the APB-style port;
// write it only while the block is idle.
module drop_oldest_burst_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	dobq_in_if.sink                          items,
	dobq_out_if.source                       results,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dobq_pkg::ADDR_W-1:0]      paddr,
	input  logic [dobq_pkg::APB_DW-1:0]      pwdata,
	output logic [dobq_pkg::APB_DW-1:0]      prdata,
	output logic                             pready
);

	logic [dobq_pkg::LIMIT_W-1:0]    max_depth_q;
	logic [dobq_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                            cfg_wr;

	logic            fifo_push, fifo_pop, fifo_full, fifo_empty;
	dobq_pkg::cmd_t  front_cmd, head_cmd;

	// Register access: word index from the byte address, unknown indexes ignored.
	assign pready  = 1'b1;
	assign reg_idx = paddr[dobq_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == dobq_pkg::REG_MAX_DEPTH) ?
		dobq_pkg::APB_DW'(max_depth_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= dobq_pkg::DEFAULT_LIMIT;
		end else if (cfg_wr && reg_idx == dobq_pkg::REG_MAX_DEPTH) begin
			max_depth_q <= pwdata[dobq_pkg::LIMIT_W-1:0];
		end
	end

	// Front: accept and classify each transfer into a command.
	dobq_front u_front (
		.items     (items),
		.max_depth (max_depth_q),
		.fifo_full (fifo_full),
		.push      (fifo_push),
		.cmd       (front_cmd)
	);

	// Hold commands between the two halves.
	dobq_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fifo_push),
		.push_cmd (front_cmd),
		.pop      (fifo_pop),
		.head_cmd (head_cmd),
		.full     (fifo_full),
		.empty    (fifo_empty)
	);

	// Back: execute against the queue storage and drive the result channel.
	dobq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.head_cmd   (head_cmd),
		.take       (fifo_pop),
		.results    (results)
	);

endmodule
`default_nettype wire
